// ===== src/tei_pkg.sv =====
package tei_pkg;

	localparam int SLOTS     = 16;
	localparam int LOOKBACK  = 9;
	localparam int CURVE_LEN = 256;

	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CI_W      = $clog2(CURVE_LEN);
	localparam int CH_W      = 2;
	localparam int CADDR_W   = SLOT_W + CH_W + CI_W;
	localparam int STAMP_W   = 48;
	localparam int OFF_W     = 16;
	localparam int LANES     = 4;
	localparam int OFFS_W    = OFF_W * LANES;
	localparam int LB_W      = $clog2(LOOKBACK + 1);
	localparam int FRAC_W    = 16;
	localparam int RATIO_W   = FRAC_W + 1;
	localparam int DIV_CNT_W = $clog2(FRAC_W);
	localparam int DUR_W     = 32;
	localparam int GAP_W     = STAMP_W + 1;
	localparam int LANE_W    = 3;

	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 72;
	localparam int PADDR_W     = 3;

	localparam logic [PADDR_W-1:0] ADDR_MAX_DUR  = PADDR_W'(0);
	localparam logic [DUR_W-1:0]   MAX_DUR_RESET = DUR_W'(1000);
	localparam logic [CH_W-1:0]    CH_NONE       = CH_W'(3);
	localparam logic [RATIO_W-1:0] RATIO_ONE     = RATIO_W'(1) << FRAC_W;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_CURVE = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W_RD,
		ST_W_EVAL,
		ST_W_CHECK,
		ST_W_RATIO,
		ST_F_NEW,
		ST_F_OLD,
		ST_F_LAST,
		ST_DIV,
		ST_L_MUL,
		ST_L_ADD,
		ST_DONE
	} state_t;

	// Step one slot back around the ring.
	function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
		prev_slot = (s == '0) ? SLOT_W'(SLOTS - 1) : s - SLOT_W'(1);
	endfunction

endpackage

// ===== src/timestamped_exposure_interpolator.sv =====
// Timestamped exposure interpolator.
// Input stream (s_*): one transaction per command. s_tuser carries the command:
// push a record, write one curve byte into the current write slot, or query.
// Only a query produces a result transaction on the output stream (m_*); the
// result carries found in m_tuser and the interpolated offsets and curve byte
// in m_tdata. max_duration is written over the APB port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A query walks back over the stamp memory one record per iteration (read,
// subtract, cap), then fetches both records' offsets and curve byte, runs a
// restoring divider when the ratio is fractional, and lerps five values through
// one shared multiplier, each in a multiply step and an add step. The walk over
// the stamp memory and the divider set how long a query takes.
// After reset the block sweeps the whole curve memory once, writing identity
// curves and clearing stamps and offsets; s_tready stays low meanwhile.
// The result sits in an output register; if the receiver stalls, the block
// still takes pushes and curve writes, and a new query waits in its last state
// until the pending result transaction is taken.
module timestamped_exposure_interpolator
	import tei_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// stamp, diff_r, diff_g, diff_b, diff_y, channel, curve_index, curve_value
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_r, out_g, out_b, out_y, curve_out
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// found
	output logic [0:0]             m_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [DUR_W-1:0]       pwdata,
	output logic [DUR_W-1:0]       prdata,
	output logic                   pready
);

	// Record memories and the curve memory. Read data is registered.
	logic [STAMP_W-1:0] stamp_mem_q [SLOTS];
	logic [OFFS_W-1:0]  offs_mem_q  [SLOTS];
	logic [CI_W-1:0]    curve_mem_q [2**CADDR_W];

	logic [STAMP_W-1:0] stamp_rd_q;
	logic [OFFS_W-1:0]  offs_rd_q;
	logic [CI_W-1:0]    curve_rd_q;

	state_t             state_q, state_d;
	logic [CADDR_W-1:0] clr_q;
	logic [SLOT_W-1:0]  wslot_q;
	logic               m_tvalid_q;
	logic [DUR_W-1:0]   max_dur_q;

	logic [STAMP_W-1:0]        qt_q;
	logic [CH_W-1:0]           qch_q;
	logic [CI_W-1:0]           qci_q;
	logic [SLOT_W-1:0]         rd_idx_q, newer_idx_q, older_idx_q;
	logic [LB_W-1:0]           j_q;
	logic [STAMP_W-1:0]        newer_q;
	logic signed [GAP_W-1:0]   gap_q, cap_q;
	logic                      ge_q;
	logic [STAMP_W-1:0]        num_q;
	logic                      div_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [DUR_W-1:0]          rem_q;
	logic [RATIO_W-1:0]        ratio_q;
	logic                      found_q;
	logic [OFFS_W-1:0]         new_offs_q, old_offs_q, res_offs_q;
	logic [CI_W-1:0]           new_curve_q, old_curve_q, res_curve_q;
	logic [LANE_W-1:0]         lane_q;
	logic signed [35:0]        prod_s1;
	logic signed [16:0]        old_s1;
	logic [OUT_TDATA_W-1:0]    out_tdata_q;
	logic                      out_found_q;

	// Input fields.
	cmd_t               in_cmd;
	logic [STAMP_W-1:0] in_ts;
	logic [OFFS_W-1:0]  in_offs;
	logic [CH_W-1:0]    in_ch;
	logic [CI_W-1:0]    in_ci;
	logic [CI_W-1:0]    in_cv;
	logic               accept;

	assign in_cmd  = cmd_t'(s_tuser);
	assign in_ts   = s_tdata[47:0];
	assign in_offs = s_tdata[111:48];
	assign in_ch   = s_tdata[113:112];
	assign in_ci   = s_tdata[121:114];
	assign in_cv   = s_tdata[129:122];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Memory write and read ports.
	logic               clearing;
	logic               stamp_we, curve_we;
	logic [SLOT_W-1:0]  rec_waddr;
	logic [STAMP_W-1:0] stamp_wdata;
	logic [OFFS_W-1:0]  offs_wdata;
	logic [CADDR_W-1:0] curve_waddr, curve_raddr;
	logic [CI_W-1:0]    curve_wdata;
	logic [SLOT_W-1:0]  offs_raddr;

	assign clearing    = (state_q == ST_CLEAR);
	assign stamp_we    = clearing ? (clr_q[SLOT_W-1:0] <= SLOT_W'(SLOTS - 1))
	                              : (accept && in_cmd == CMD_PUSH);
	assign rec_waddr   = clearing ? clr_q[SLOT_W-1:0] : wslot_q;
	assign stamp_wdata = clearing ? '0 : in_ts;
	assign offs_wdata  = clearing ? '0 : in_offs;
	assign curve_we    = clearing || (accept && in_cmd == CMD_CURVE && in_ch != CH_NONE);
	assign curve_waddr = clearing ? clr_q : {wslot_q, in_ch, in_ci};
	assign curve_wdata = clearing ? clr_q[CI_W-1:0] : in_cv;
	assign offs_raddr  = (state_q == ST_F_OLD) ? older_idx_q : newer_idx_q;
	assign curve_raddr = {offs_raddr, qch_q, qci_q};

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem_q[rec_waddr] <= stamp_wdata;
			offs_mem_q[rec_waddr]  <= offs_wdata;
		end
		stamp_rd_q <= stamp_mem_q[rd_idx_q];
		offs_rd_q  <= offs_mem_q[offs_raddr];
	end

	always_ff @(posedge clk) begin
		if (curve_we) begin
			curve_mem_q[curve_waddr] <= curve_wdata;
		end
		curve_rd_q <= curve_mem_q[curve_raddr];
	end

	// The gap capped at max_duration; a negative gap stays negative.
	logic signed [GAP_W-1:0] max_ext, capgap;
	logic                    qualifies;

	assign max_ext   = $signed({{(GAP_W - DUR_W){1'b0}}, max_dur_q});
	assign capgap    = (gap_q > max_ext) ? max_ext : gap_q;
	assign qualifies = ge_q && (capgap != '0);

	// One restoring division step.
	logic [DUR_W:0] rem2, div_sub;
	logic           div_take;

	assign rem2     = {rem_q, 1'b0};
	assign div_sub  = rem2 - {1'b0, cap_q[DUR_W-1:0]};
	assign div_take = (rem2 >= {1'b0, cap_q[DUR_W-1:0]});

	// Lerp operands of the current lane.
	logic signed [16:0] lane_old, lane_new;
	logic signed [17:0] lane_diff;
	logic signed [35:0] lerp_sum;

	always_comb begin
		case (lane_q)
			LANE_W'(0): begin
				lane_old = 17'(signed'(old_offs_q[15:0]));
				lane_new = 17'(signed'(new_offs_q[15:0]));
			end
			LANE_W'(1): begin
				lane_old = 17'(signed'(old_offs_q[31:16]));
				lane_new = 17'(signed'(new_offs_q[31:16]));
			end
			LANE_W'(2): begin
				lane_old = 17'(signed'(old_offs_q[47:32]));
				lane_new = 17'(signed'(new_offs_q[47:32]));
			end
			LANE_W'(3): begin
				lane_old = 17'(signed'(old_offs_q[63:48]));
				lane_new = 17'(signed'(new_offs_q[63:48]));
			end
			default: begin
				lane_old = $signed({9'b0, old_curve_q});
				lane_new = $signed({9'b0, new_curve_q});
			end
		endcase
	end

	assign lane_diff = 18'(lane_new) - 18'(lane_old);
	// The high half of old * 2^16 + diff * ratio is the floored result.
	assign lerp_sum  = $signed({{3{old_s1[16]}}, old_s1, 16'b0}) + prod_s1;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:    if (accept && in_cmd == CMD_QUERY) state_d = ST_W_RD;
			ST_W_RD:    state_d = ST_W_EVAL;
			ST_W_EVAL:  state_d = (j_q == '0) ? ST_W_RD : ST_W_CHECK;
			ST_W_CHECK: begin
				if (qualifies) begin
					state_d = ST_W_RATIO;
				end else if (j_q == LB_W'(LOOKBACK)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_W_RD;
				end
			end
			ST_W_RATIO: state_d = ST_F_NEW;
			ST_F_NEW:   state_d = ST_F_OLD;
			ST_F_OLD:   state_d = ST_F_LAST;
			ST_F_LAST:  state_d = div_q ? ST_DIV : ST_L_MUL;
			ST_DIV:     if (div_cnt_q == '1) state_d = ST_L_MUL;
			ST_L_MUL:   state_d = ST_L_ADD;
			ST_L_ADD:   state_d = (lane_q == LANE_W'(LANES)) ? ST_DONE : ST_L_MUL;
			ST_DONE:    if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			wslot_q    <= '0;
			m_tvalid_q <= 1'b0;
			max_dur_q  <= MAX_DUR_RESET;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + CADDR_W'(1);
			end
			if (accept && in_cmd == CMD_PUSH) begin
				wslot_q <= (wslot_q == SLOT_W'(SLOTS - 1)) ? '0 : wslot_q + SLOT_W'(1);
			end
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_MAX_DUR) begin
				max_dur_q <= pwdata;
			end
		end
	end

	// Query datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd == CMD_QUERY) begin
					qt_q        <= in_ts;
					qch_q       <= in_ch;
					qci_q       <= in_ci;
					rd_idx_q    <= prev_slot(wslot_q);
					j_q         <= '0;
					found_q     <= 1'b0;
					res_offs_q  <= '0;
					res_curve_q <= in_ci;
				end
			end
			ST_W_EVAL: begin
				if (j_q == '0) begin
					newer_q     <= stamp_rd_q;
					newer_idx_q <= rd_idx_q;
					rd_idx_q    <= prev_slot(rd_idx_q);
					j_q         <= LB_W'(1);
				end else begin
					gap_q       <= $signed({1'b0, newer_q}) - $signed({1'b0, stamp_rd_q});
					ge_q        <= (qt_q >= newer_q);
					older_idx_q <= rd_idx_q;
				end
			end
			ST_W_CHECK: begin
				cap_q <= capgap;
				num_q <= qt_q - newer_q;
				if (!qualifies) begin
					// The older record becomes the newer one of the next pair.
					newer_q     <= stamp_rd_q;
					newer_idx_q <= older_idx_q;
					rd_idx_q    <= prev_slot(rd_idx_q);
					j_q         <= j_q + LB_W'(1);
				end
			end
			ST_W_RATIO: begin
				found_q   <= 1'b1;
				div_cnt_q <= '0;
				rem_q     <= num_q[DUR_W-1:0];
				if (cap_q[GAP_W-1]) begin
					ratio_q <= '0;
					div_q   <= 1'b0;
				end else if ({1'b0, num_q} >= $unsigned(cap_q)) begin
					ratio_q <= RATIO_ONE;
					div_q   <= 1'b0;
				end else begin
					ratio_q <= '0;
					div_q   <= 1'b1;
				end
			end
			ST_F_OLD: begin
				new_offs_q  <= offs_rd_q;
				new_curve_q <= curve_rd_q;
			end
			ST_F_LAST: begin
				old_offs_q  <= offs_rd_q;
				old_curve_q <= curve_rd_q;
				lane_q      <= '0;
			end
			ST_DIV: begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				rem_q     <= div_take ? div_sub[DUR_W-1:0] : rem2[DUR_W-1:0];
				ratio_q   <= {ratio_q[RATIO_W-2:0], div_take};
			end
			ST_L_MUL: begin
				prod_s1 <= lane_diff * $signed({1'b0, ratio_q});
				old_s1  <= lane_old;
			end
			ST_L_ADD: begin
				lane_q <= lane_q + LANE_W'(1);
				case (lane_q)
					LANE_W'(0): res_offs_q[15:0]  <= lerp_sum[31:16];
					LANE_W'(1): res_offs_q[31:16] <= lerp_sum[31:16];
					LANE_W'(2): res_offs_q[47:32] <= lerp_sum[31:16];
					LANE_W'(3): res_offs_q[63:48] <= lerp_sum[31:16];
					default: begin
						// Channel three has no curve; the index stands.
						if (qch_q != CH_NONE) res_curve_q <= lerp_sum[23:16];
					end
				endcase
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_tdata_q <= {res_curve_q, res_offs_q};
					out_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_tdata_q;
	assign m_tuser  = out_found_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_DUR) ? max_dur_q : '0;

endmodule

// ===== src/tei_checker.sv =====
module tei_checker
	import tei_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [1:0]             s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [0:0]             m_tuser
);

	// A stalled result holds.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A result without a qualifying pair carries zero offsets.
	a_default_offsets: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == '0)
		else $error("default result with nonzero offsets");

	// Pushes, curve writes and unused commands never cause a result.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != CMD_QUERY |=> !$rose(m_tvalid))
		else $error("result after a non-query transaction");

endmodule

bind timestamped_exposure_interpolator tei_checker u_tei_checker (.*);
